### rtl/core/bse_pkg.sv
// shared types and constants for the binary search engine
`timescale 1ns / 1ps

package bse_pkg;

  // request kind codes
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // config register word indexes
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // field widths fixed by the interface
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned PROBE_W = 4;

  // probe counter ceiling
  localparam logic [PROBE_W-1:0] PROBE_MAX = 4'd15;

  // input request payload
  typedef struct packed {
    logic                    kind;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] search_key;
  } bse_req_t;

  // result payload
  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   match_index;
    logic [PROBE_W-1:0] probe_count;
  } bse_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic wr_en;     // store the request's entry
    logic start;     // load key and interval bounds
    logic probe;     // count a probe and read the midpoint entry
    logic update;    // compare and narrow the interval
    logic load_out;  // capture the result into the output register
  } bse_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;  // interval is empty
    logic hit;    // fetched entry equals the key
  } bse_sts_t;

endpackage

### rtl/core/bse_regs.sv
// apb config register block holding the entry count
`timescale 1ns / 1ps

module bse_regs
  import bse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [COUNT_W-1:0] entry_count_o
);

  logic [COUNT_W-1:0] entry_count_q;
  logic               wr_hit;

  // word index 0 holds entry_count
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (wr_hit) begin
      entry_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ENTRY_COUNT) begin
      prdata = {{(32-COUNT_W){1'b0}}, entry_count_q};
    end
  end

  assign pready        = 1'b1;
  assign entry_count_o = entry_count_q;

endmodule

### rtl/core/bse_ctrl.sv
// search sequencer: accepts requests and steps the probe loop
`timescale 1ns / 1ps

module bse_ctrl
  import bse_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_kind_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  bse_sts_t sts_i,
  output bse_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // command decode
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.wr_en = in_fire && (in_kind_i == KIND_WRITE);
        cmd_o.start = in_fire && (in_kind_i == KIND_SEARCH);
      end
      ST_PROBE:   cmd_o.probe    = 1'b1;
      ST_COMPARE: cmd_o.update   = 1'b1;
      ST_FINISH:  cmd_o.load_out = out_free;
      default:    cmd_o = '0;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && (in_kind_i == KIND_SEARCH)) begin
            state_q <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          state_q <= sts_i.empty ? ST_FINISH : ST_COMPARE;
        end
        ST_COMPARE: begin
          state_q <= sts_i.hit ? ST_FINISH : ST_PROBE;
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/bse_dp.sv
// datapath: table memory, interval bounds, compare and result register
`timescale 1ns / 1ps

module bse_dp
  import bse_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  bse_req_t           req_i,
  input  logic [COUNT_W-1:0] entry_count_i,
  input  bse_cmd_t           cmd_i,
  output bse_sts_t           sts_o,
  output bse_rsp_t           rsp_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IW = AW + 2;
  localparam int unsigned NW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
  localparam int unsigned WW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

  logic [VAL_W-1:0]        mem [TABLE_DEPTH];
  logic signed [VAL_W-1:0] rd_q;
  logic signed [VAL_W-1:0] key_q;
  logic signed [IW-1:0]    lo_q, hi_q;
  logic [AW-1:0]           mid_q;
  logic [PROBE_W-1:0]      probes_q;
  logic                    found_q;
  bse_rsp_t                rsp_q;

  logic [NW-1:0]           cnt_ext;
  logic [NW-1:0]           n_sat;
  logic [WW-1:0]           widx;
  logic                    widx_ok;
  logic [IW-1:0]           sum;
  logic [AW-1:0]           mid;
  logic [AW+IDX_W-1:0]     mid_ext;

  // search length clipped to the table depth
  assign cnt_ext = NW'(entry_count_i);
  assign n_sat   = (cnt_ext < NW'(TABLE_DEPTH)) ? cnt_ext : NW'(TABLE_DEPTH);

  // write address range check
  assign widx    = WW'(req_i.entry_index);
  assign widx_ok = widx < WW'(TABLE_DEPTH);

  // midpoint of the current interval
  assign sum = lo_q + hi_q;
  assign mid = sum[AW:1];

  assign sts_o.empty = lo_q > hi_q;
  assign sts_o.hit   = rd_q == key_q;

  // table write and midpoint read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && widx_ok) begin
      mem[widx[AW-1:0]] <= req_i.entry_value;
    end
    if (cmd_i.probe && !sts_o.empty) begin
      rd_q  <= mem[mid];
      mid_q <= mid;
    end
  end

  // interval bounds, probe count and result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q    <= req_i.search_key;
      lo_q     <= '0;
      hi_q     <= $signed({1'b0, n_sat[AW:0]}) - IW'(1);
      probes_q <= '0;
      found_q  <= 1'b0;
    end
    if (cmd_i.probe && (probes_q != PROBE_MAX)) begin
      probes_q <= probes_q + PROBE_W'(1);
    end
    if (cmd_i.update) begin
      if (sts_o.hit) begin
        found_q <= 1'b1;
      end else if (rd_q < key_q) begin
        lo_q <= $signed(IW'(mid_q)) + IW'(1);
      end else begin
        hi_q <= $signed(IW'(mid_q)) - IW'(1);
      end
    end
    if (cmd_i.load_out) begin
      rsp_q.found       <= found_q;
      rsp_q.match_index <= found_q ? mid_ext[IDX_W-1:0] : '0;
      rsp_q.probe_count <= probes_q;
    end
  end

  assign mid_ext = {{IDX_W{1'b0}}, mid_q};
  assign rsp_o   = rsp_q;

endmodule

### rtl/core/binary_search_engine_top.sv
// top level of the binary search engine
//
//   channel   | direction | handshake              | payload
//   request   | in        | in_valid_i/in_ready_o  | in_req_i  (bse_req_t)
//   result    | out       | out_valid_o/out_ready_i| out_rsp_o (bse_rsp_t)
//   config    | in        | apb psel/penable       | entry_count at byte 0
//
// a write request leaves the block ready again in the next cycle
// a search alternates a probe step, which reads the midpoint entry, with a compare step
// that narrows the interval; it ends on a hit, or at the probe step on an empty interval
// each probe depends on the interval left by the compare before it
// reset clears the sequencer, the result valid and entry_count; the table is not cleared
// a held result stalls only the next search at its finish step; until then new requests are still taken
`timescale 1ns / 1ps

module binary_search_engine_top
  import bse_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  bse_req_t    in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output bse_rsp_t    out_rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [COUNT_W-1:0] entry_count;
  bse_cmd_t           cmd;
  bse_sts_t           sts;

  // config registers
  bse_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .entry_count_o (entry_count)
  );

  // sequencer
  bse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_req_i.kind),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  bse_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .req_i         (in_req_i),
    .entry_count_i (entry_count),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rsp_o         (out_rsp_o)
  );

endmodule

### rtl/core/bse_checker.sv
// port-level checks for the binary search engine, bound to the top level
`timescale 1ns / 1ps

module bse_checker
  import bse_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input bse_req_t in_req_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input bse_rsp_t out_rsp_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // a search request occupies the engine on the next cycle
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.kind == KIND_SEARCH) |=> !in_ready_o)
    else $error("ready after search request");

  // a write request leaves the engine ready on the next cycle
  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.kind == KIND_WRITE) |=> in_ready_o)
    else $error("not ready after write request");

  // a miss reports index zero and every result counts at least one probe
  a_result_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.found || (out_rsp_o.match_index == '0))
                    && (out_rsp_o.probe_count != '0))
    else $error("inconsistent result");

endmodule

bind binary_search_engine_top bse_checker u_bse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
